[src/msxu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msxu_pkg;

   localparam int          SCRATCH_BYTES = 16384;
   localparam logic [31:0] BOOT_VECTOR   = 32'hBFC0_0000;
   localparam logic [31:0] TLBWI_WORD    = 32'h4200_0002;
   localparam logic [31:0] SCRATCH_BASE  = 32'h7000_0000;
   localparam logic [31:0] PHYS_MASK     = 32'h1FFF_FFFF;

   // major opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // special function codes
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_SYNC = 6'h0F;

   // cop0 move formats
   localparam logic [4:0] CP0_MF = 5'd0;
   localparam logic [4:0] CP0_MT = 5'd4;

   typedef enum logic [2:0] {
      ST_EXECUTED        = 3'd0,
      ST_UNKNOWN_SPECIAL = 3'd1,
      ST_ILLEGAL         = 3'd2,
      ST_STOPPED         = 3'd3,
      ST_COP0_MOVE       = 3'd4
   } status_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_write_type;

endpackage

`default_nettype wire

[src/msxu_regfile.sv]
`timescale 1ns / 1ps
`default_nettype none

// 32x32 register file: one synchronous memory, two registered read ports,
// one write port. Valid bits make unwritten entries read as zero after reset.
module msxu_regfile (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         rd_en,
   input  wire [4:0]                   rs_addr,
   input  wire [4:0]                   rt_addr,
   input  wire msxu_pkg::rf_write_type wr,
   output logic [31:0]                 rs_data,
   output logic [31:0]                 rt_data
);

   logic [31:0] mem [32];
   logic [31:0] entry_valid_ff;

   logic [31:0] rs_mem_ff;
   logic [31:0] rt_mem_ff;
   logic        rs_valid_ff;
   logic        rt_valid_ff;
   logic [4:0]  rs_addr_ff;
   logic [4:0]  rt_addr_ff;

   // last write, used to bypass a write landing on the same edge as the read
   msxu_pkg::rf_write_type last_wr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rs_mem_ff  <= mem[rs_addr];
         rt_mem_ff  <= mem[rt_addr];
         rs_addr_ff <= rs_addr;
         rt_addr_ff <= rt_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rs_valid_ff    <= 1'b0;
         rt_valid_ff    <= 1'b0;
         last_wr_ff     <= '0;
      end else begin
         if (rd_en) begin
            rs_valid_ff <= entry_valid_ff[rs_addr];
            rt_valid_ff <= entry_valid_ff[rt_addr];
         end
         if (wr.en) begin
            entry_valid_ff[wr.addr] <= 1'b1;
            last_wr_ff              <= wr;
         end
      end
   end

   always_comb begin
      if (last_wr_ff.en && last_wr_ff.addr == rs_addr_ff) begin
         rs_data = last_wr_ff.data;
      end else begin
         rs_data = rs_valid_ff ? rs_mem_ff : '0;
      end
      if (last_wr_ff.en && last_wr_ff.addr == rt_addr_ff) begin
         rt_data = last_wr_ff.data;
      end else begin
         rt_data = rt_valid_ff ? rt_mem_ff : '0;
      end
   end

endmodule

`default_nettype wire

[src/mips_subset_execute_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Execute unit for a small MIPS32 integer subset.
// Request channel (req_valid / req_ready / req_instruction): one fetched
// instruction word per request, taken at the current program counter.
// Response channel (rsp_valid / rsp_ready / rsp_*): exactly one response per
// request, in order: a status code, an optional word store (translated to a
// scratchpad offset or a bus physical address, else as is) and the next fetch
// address. The execute stage holds an accepted request while the register
// file read for it lands, then registers its result in the response register.
// Throughput: one request per cycle while rsp_ready is high. The register
// file read at accept time lands in the read registers of the memory, and
// the write of the instruction ahead of it is bypassed, so back-to-back
// dependent instructions run at full rate.
// Reset: register file reads as zero (per-entry valid bits), program counter
// at the boot vector, no pending branch, unit running. Reset takes effect at
// once; there is no clearing pass.
// Stall: while a response waits with rsp_ready low the response register
// holds, the execute stage holds its request and req_ready drops once that
// stage is occupied. After an unknown or illegal code the unit answers every
// further request with the stopped status until reset.
module mips_subset_execute_unit_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_instruction,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_store_valid,
   output logic        rsp_store_to_scratchpad,
   output logic [31:0] rsp_store_address,
   output logic [31:0] rsp_store_data,
   output logic [31:0] rsp_fetch_address
);

   // ---------------------------------------------------------------
   // Handshake and execute stage
   // ---------------------------------------------------------------
   logic        accept;
   logic        out_free;
   logic        s1_adv;
   logic        s1_valid_ff;
   logic [31:0] s1_inst_ff;
   logic        rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_inst_ff <= req_instruction;
      end
   end

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   msxu_pkg::rf_write_type rf_wr;
   logic [31:0]            a_val;
   logic [31:0]            b_val;

   msxu_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rs_addr (req_instruction[25:21]),
      .rt_addr (req_instruction[20:16]),
      .wr      (rf_wr),
      .rs_data (a_val),
      .rt_data (b_val)
   );

   // ---------------------------------------------------------------
   // Architectural state
   // ---------------------------------------------------------------
   logic [31:0] pc_ff,      pc_in;
   logic        pending_ff, pending_in;
   logic [31:0] target_ff,  target_in;
   logic        stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= msxu_pkg::BOOT_VECTOR;
         pending_ff <= 1'b0;
         target_ff  <= '0;
         stopped_ff <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         pending_ff <= pending_in;
         target_ff  <= target_in;
         stopped_ff <= stopped_in;
      end
   end

   // ---------------------------------------------------------------
   // Decode and execute
   // ---------------------------------------------------------------
   logic [5:0]  op;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [15:0] imm;
   logic [31:0] imm_sext;
   logic [31:0] addr_sum;
   logic [31:0] scratch_off;
   logic        in_scratch;
   logic        bus_fold;
   logic [31:0] pc_plus4;

   assign op       = s1_inst_ff[31:26];
   assign rs       = s1_inst_ff[25:21];
   assign rt       = s1_inst_ff[20:16];
   assign imm      = s1_inst_ff[15:0];
   assign imm_sext = {{16{imm[15]}}, imm};
   assign addr_sum = a_val + imm_sext;
   assign pc_plus4 = pc_ff + 32'd4;

   // scratchpad window is inclusive of its base, exclusive of base + size
   assign scratch_off = addr_sum - msxu_pkg::SCRATCH_BASE;
   assign in_scratch  = (addr_sum >= msxu_pkg::SCRATCH_BASE) &&
                        (scratch_off < 32'(msxu_pkg::SCRATCH_BYTES));
   // low user space, kseg1, and the top of kseg0 fold to physical
   assign bus_fold = !addr_sum[31] || (addr_sum[31:29] == 3'b101) ||
                     (addr_sum[31:22] == 10'b1001_1111_11);

   msxu_pkg::status_type status;
   logic        halt;
   logic        take;
   logic [31:0] take_target;
   logic        wr_req;
   logic [31:0] wr_val;
   logic        st_valid;
   logic        st_scratch;
   logic [31:0] st_addr;

   always_comb begin
      status      = msxu_pkg::ST_EXECUTED;
      halt        = 1'b0;
      take        = 1'b0;
      take_target = a_val;
      wr_req      = 1'b0;
      wr_val      = addr_sum;
      st_valid    = 1'b0;
      st_scratch  = 1'b0;
      st_addr     = '0;

      if (stopped_ff) begin
         status = msxu_pkg::ST_STOPPED;
      end else if (s1_inst_ff != msxu_pkg::TLBWI_WORD) begin
         case (op)
            msxu_pkg::OP_SPECIAL: begin
               if (s1_inst_ff != '0) begin
                  if (s1_inst_ff[5:0] == msxu_pkg::FN_JR) begin
                     if (s1_inst_ff[20:6] != '0) begin
                        status = msxu_pkg::ST_ILLEGAL;
                        halt   = 1'b1;
                     end else begin
                        take        = 1'b1;
                        take_target = a_val;
                     end
                  end else if (s1_inst_ff[5:0] != msxu_pkg::FN_SYNC) begin
                     status = msxu_pkg::ST_UNKNOWN_SPECIAL;
                     halt   = 1'b1;
                  end
               end
            end
            msxu_pkg::OP_BNE: begin
               if (a_val != b_val) begin
                  take        = 1'b1;
                  take_target = pc_plus4 + {imm_sext[29:0], 2'b00};
               end
            end
            msxu_pkg::OP_ADDI, msxu_pkg::OP_ADDIU: begin
               wr_req = 1'b1;
               wr_val = addr_sum;
            end
            msxu_pkg::OP_SLTI: begin
               wr_req = 1'b1;
               wr_val = {31'd0, ($signed(a_val) < $signed(imm_sext))};
            end
            msxu_pkg::OP_ORI: begin
               wr_req = 1'b1;
               wr_val = a_val | {16'd0, imm};
            end
            msxu_pkg::OP_LUI: begin
               wr_req = 1'b1;
               wr_val = {imm, 16'd0};
            end
            msxu_pkg::OP_COP0: begin
               if (rs == msxu_pkg::CP0_MF || rs == msxu_pkg::CP0_MT) begin
                  status = msxu_pkg::ST_COP0_MOVE;
               end else begin
                  status = msxu_pkg::ST_ILLEGAL;
                  halt   = 1'b1;
               end
            end
            msxu_pkg::OP_SW: begin
               st_valid = 1'b1;
               if (in_scratch) begin
                  st_scratch = 1'b1;
                  st_addr    = scratch_off;
               end else if (bus_fold) begin
                  st_addr = addr_sum & msxu_pkg::PHYS_MASK;
               end else begin
                  st_addr = addr_sum;
               end
            end
            default: begin
               status = msxu_pkg::ST_ILLEGAL;
               halt   = 1'b1;
            end
         endcase
      end
   end

   // Advance the program counter and the delay-slot target; hold them and the
   // pending flag when stopped or stopping.
   logic commit;

   assign commit = s1_adv && !stopped_ff && !halt;

   always_comb begin
      pc_in      = pc_ff;
      pending_in = pending_ff;
      target_in  = target_ff;
      stopped_in = stopped_ff;
      if (s1_adv && !stopped_ff && halt) begin
         stopped_in = 1'b1;
      end
      if (commit) begin
         pc_in      = pending_ff ? target_ff : pc_plus4;
         pending_in = take;
         if (take) begin
            target_in = take_target;
         end
      end
   end

   // drop writes to register zero
   assign rf_wr = '{en:   commit && wr_req && (rt != 5'd0),
                    addr: rt,
                    data: wr_val};

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic [2:0]  rsp_status_ff;
   logic        rsp_store_valid_ff;
   logic        rsp_scratch_ff;
   logic [31:0] rsp_addr_ff;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_status_ff      <= status;
         rsp_store_valid_ff <= st_valid;
         rsp_scratch_ff     <= st_scratch;
         rsp_addr_ff        <= st_addr;
         rsp_data_ff        <= st_valid ? b_val : '0;
         rsp_fetch_ff       <= pc_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_store_valid         = rsp_store_valid_ff;
   assign rsp_store_to_scratchpad = rsp_scratch_ff;
   assign rsp_store_address       = rsp_addr_ff;
   assign rsp_store_data          = rsp_data_ff;
   assign rsp_fetch_address       = rsp_fetch_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> rf_wr.addr != 5'd0)
      else $error("register zero written");

   a_stopped_status: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && stopped_ff) |=> rsp_status == msxu_pkg::ST_STOPPED)
      else $error("stopped unit reported a non-stopped status");

   a_stopped_pc_hold: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> $stable(pc_ff) && stopped_ff)
      else $error("program counter moved while stopped");

   a_fetch_matches_pc: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_fetch_address == pc_ff)
      else $error("fetch address differs from program counter");

endmodule

`default_nettype wire

[tb/mips_subset_execute_unit_core_tb.sv]
`timescale 1ns / 1ps

module mips_subset_execute_unit_core_tb;

   // One retired instruction as the response channel reports it.
   typedef struct packed {
      msxu_pkg::status_type status;
      logic                 store_valid;
      logic                 store_to_scratchpad;
      logic [31:0]          store_address;
      logic [31:0]          store_data;
      logic [31:0]          fetch_address;
   } retire_info_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [31:0] req_instruction = 32'h0;
   logic        rsp_ready = 1'b0;
   wire         req_ready;
   wire         rsp_valid;
   wire  [2:0]  rsp_status;
   wire         rsp_store_valid;
   wire         rsp_store_to_scratchpad;
   wire  [31:0] rsp_store_address;
   wire  [31:0] rsp_store_data;
   wire  [31:0] rsp_fetch_address;

   mips_subset_execute_unit_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_instruction         (req_instruction),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_store_valid         (rsp_store_valid),
      .rsp_store_to_scratchpad (rsp_store_to_scratchpad),
      .rsp_store_address       (rsp_store_address),
      .rsp_store_data          (rsp_store_data),
      .rsp_fetch_address       (rsp_fetch_address)
   );

   always #2 clock = ~clock;

   // Instruction words waiting to be offered, and retirements predicted for
   // requests already accepted, oldest first.
   logic [31:0]     instr_q[$];
   retire_info_type predicted_retires[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned requests_queued = 0;
   int unsigned retires_checked = 0;
   int unsigned mismatch_count = 0;

   // Architectural state of the predicted core.
   logic [31:0] arch_regs [32];
   logic [31:0] arch_pc;
   logic        slot_pending;
   logic [31:0] slot_target;
   logic        halted;

   // ------------------------------------------------------------------
   // Prediction: execute one instruction word against the shadow state
   // and return what the unit must report for it.
   // ------------------------------------------------------------------
   function automatic retire_info_type execute_instruction(logic [31:0] inst);
      logic [5:0]      op;
      logic [4:0]      rs, rt;
      logic [31:0]     simm, a, b, ea, scratch_off, branch_to, next_pc, wb_val;
      logic            take, halt, wb_en;
      retire_info_type r;
      op   = inst[31:26];
      rs   = inst[25:21];
      rt   = inst[20:16];
      simm = {{16{inst[15]}}, inst[15:0]};
      a    = arch_regs[rs];
      b    = arch_regs[rt];
      r    = '0;
      r.status  = msxu_pkg::ST_EXECUTED;
      take      = 1'b0;
      halt      = 1'b0;
      wb_en     = 1'b0;
      wb_val    = 32'h0;
      branch_to = 32'h0;
      if (halted) begin
         r.status = msxu_pkg::ST_STOPPED;
      end else begin
         // tlbwi sits in the cop0 space but is a plain no-op here
         if (inst != msxu_pkg::TLBWI_WORD) begin
            case (op)
               msxu_pkg::OP_SPECIAL: begin
                  if (inst != 32'h0) begin
                     if (inst[5:0] == msxu_pkg::FN_JR) begin
                        if (inst[20:6] != 15'h0) begin
                           r.status = msxu_pkg::ST_ILLEGAL;
                           halt     = 1'b1;
                        end else begin
                           take      = 1'b1;
                           branch_to = a;
                        end
                     end else if (inst[5:0] != msxu_pkg::FN_SYNC) begin
                        r.status = msxu_pkg::ST_UNKNOWN_SPECIAL;
                        halt     = 1'b1;
                     end
                  end
               end
               msxu_pkg::OP_BNE: begin
                  if (a != b) begin
                     take      = 1'b1;
                     branch_to = arch_pc + 32'd4 + (simm << 2);
                  end
               end
               msxu_pkg::OP_ADDI, msxu_pkg::OP_ADDIU: begin
                  // no overflow trap: wrap
                  wb_en  = 1'b1;
                  wb_val = a + simm;
               end
               msxu_pkg::OP_SLTI: begin
                  wb_en  = 1'b1;
                  wb_val = {31'h0, $signed(a) < $signed(simm)};
               end
               msxu_pkg::OP_ORI: begin
                  wb_en  = 1'b1;
                  wb_val = a | {16'h0, inst[15:0]};
               end
               msxu_pkg::OP_LUI: begin
                  wb_en  = 1'b1;
                  wb_val = {inst[15:0], 16'h0};
               end
               msxu_pkg::OP_COP0: begin
                  if (rs == msxu_pkg::CP0_MF || rs == msxu_pkg::CP0_MT) begin
                     r.status = msxu_pkg::ST_COP0_MOVE;
                  end else begin
                     r.status = msxu_pkg::ST_ILLEGAL;
                     halt     = 1'b1;
                  end
               end
               msxu_pkg::OP_SW: begin
                  r.store_valid = 1'b1;
                  r.store_data  = b;
                  ea            = a + simm;
                  scratch_off   = ea - msxu_pkg::SCRATCH_BASE;
                  if (ea >= msxu_pkg::SCRATCH_BASE &&
                      scratch_off < 32'(msxu_pkg::SCRATCH_BYTES)) begin
                     r.store_to_scratchpad = 1'b1;
                     r.store_address       = scratch_off;
                  end else if (ea <= 32'h7FFF_FFFF ||
                               (ea >= 32'hA000_0000 && ea <= 32'hBFFF_FFFF) ||
                               (ea >= 32'h9FC0_0000 && ea <= 32'h9FFF_FFFF)) begin
                     r.store_address = ea & msxu_pkg::PHYS_MASK;
                  end else begin
                     r.store_address = ea;
                  end
               end
               default: begin
                  r.status = msxu_pkg::ST_ILLEGAL;
                  halt     = 1'b1;
               end
            endcase
         end
         if (wb_en && rt != 5'd0)
            arch_regs[rt] = wb_val;
         if (halt) begin
            // leave pc alone: fetch points back at the offending word
            halted = 1'b1;
         end else begin
            // a pending target wins over pc+4; a new branch waits one slot
            next_pc = arch_pc + 32'd4;
            if (slot_pending) begin
               next_pc      = slot_target;
               slot_pending = 1'b0;
            end
            if (take) begin
               slot_pending = 1'b1;
               slot_target  = branch_to;
            end
            arch_pc = next_pc;
         end
      end
      r.fetch_address = arch_pc;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Instruction builders.
   // ------------------------------------------------------------------
   function automatic logic [31:0] encode_imm(logic [5:0] op, logic [4:0] rs,
                                              logic [4:0] rt, logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // Favor a handful of registers so that results feed later instructions.
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 3) == 0)
         return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Any instruction that keeps the unit running.
   function automatic logic [31:0] random_instruction();
      logic [4:0]  rs, rt;
      logic [15:0] imm;
      rs  = pick_reg();
      rt  = pick_reg();
      imm = pick_imm();
      case ($urandom_range(0, 15))
         0:       return 32'h0;
         1:       return msxu_pkg::TLBWI_WORD;
         2:       return {msxu_pkg::OP_SPECIAL, 20'($urandom), msxu_pkg::FN_SYNC};
         3:       return encode_imm(msxu_pkg::OP_SPECIAL, rs, 5'd0,
                                    {10'h0, msxu_pkg::FN_JR});
         4, 5:    return encode_imm(msxu_pkg::OP_BNE, rs, rt, imm);
         6:       return encode_imm(msxu_pkg::OP_ADDI, rs, rt, imm);
         7:       return encode_imm(msxu_pkg::OP_ADDIU, rs, rt, imm);
         8:       return encode_imm(msxu_pkg::OP_SLTI, rs, rt, imm);
         9, 10:   return encode_imm(msxu_pkg::OP_ORI, rs, rt, imm);
         11:      return encode_imm(msxu_pkg::OP_LUI, rs, rt, imm);
         12, 13:  return encode_imm(msxu_pkg::OP_SW, rs, rt, imm);
         14:      return {msxu_pkg::OP_COP0,
                          ($urandom_range(0, 1) ? msxu_pkg::CP0_MT : msxu_pkg::CP0_MF),
                          21'($urandom)};
         default: return encode_imm(msxu_pkg::OP_BNE, rs, rs, imm);
      endcase
   endfunction

   task automatic push_request(logic [31:0] word);
      instr_q.push_back(word);
      requests_queued++;
   endtask

   // Build a base near a translation boundary, then store through it.
   task automatic queue_store_probe();
      logic [31:0] target, base;
      logic [15:0] off;
      logic [4:0]  rb;
      case ($urandom_range(0, 7))
         0:       target = msxu_pkg::SCRATCH_BASE;
         1:       target = msxu_pkg::SCRATCH_BASE + 32'(msxu_pkg::SCRATCH_BYTES);
         2:       target = 32'h8000_0000;
         3:       target = 32'h9FC0_0000;
         4:       target = 32'hA000_0000;
         5:       target = 32'hC000_0000;
         6:       target = 32'h0000_0000;
         default: target = $urandom;
      endcase
      target = target + $urandom_range(0, 16) - 32'd8;
      off    = pick_imm();
      base   = target - {{16{off[15]}}, off};
      rb     = 5'($urandom_range(1, 7));
      push_request(encode_imm(msxu_pkg::OP_LUI, 5'd0, rb, base[31:16]));
      push_request(encode_imm(msxu_pkg::OP_ORI, rb, rb, base[15:0]));
      push_request(encode_imm(msxu_pkg::OP_SW, rb, pick_reg(), off));
   endtask

   // Branch with another branch in its delay slot.
   task automatic queue_branch_chain();
      push_request(encode_imm(msxu_pkg::OP_BNE, pick_reg(), pick_reg(), pick_imm()));
      if ($urandom_range(0, 1))
         push_request(encode_imm(msxu_pkg::OP_BNE, pick_reg(), pick_reg(), pick_imm()));
      else
         push_request(encode_imm(msxu_pkg::OP_SPECIAL, pick_reg(), 5'd0,
                                 {10'h0, msxu_pkg::FN_JR}));
      push_request(random_instruction());
   endtask

   task automatic queue_random_traffic(int unsigned count);
      int unsigned stop_at;
      stop_at = requests_queued + count;
      while (requests_queued < stop_at) begin
         case ($urandom_range(0, 8))
            6, 7:    queue_store_probe();
            8:       queue_branch_chain();
            default: push_request(random_instruction());
         endcase
      end
   endtask

   task automatic queue_directed();
      push_request(encode_imm(msxu_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF));
      push_request(encode_imm(msxu_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));  // r1 = all ones
      push_request(encode_imm(msxu_pkg::OP_ADDI, 5'd1, 5'd2, 16'h0001)); // wraps to zero
      push_request(encode_imm(msxu_pkg::OP_LUI, 5'd0, 5'd3, 16'h7FFF));
      push_request(encode_imm(msxu_pkg::OP_ORI, 5'd3, 5'd3, 16'hFFFF));  // max positive
      push_request(encode_imm(msxu_pkg::OP_ADDI, 5'd3, 5'd4, 16'h0001)); // overflow, no trap
      push_request(encode_imm(msxu_pkg::OP_ADDIU, 5'd3, 5'd0, 16'h0005)); // r0 write dropped
      push_request(encode_imm(msxu_pkg::OP_SLTI, 5'd4, 5'd5, 16'h0000)); // most negative < 0
      push_request(encode_imm(msxu_pkg::OP_SLTI, 5'd3, 5'd6, 16'hFFFF)); // max positive vs -1
      push_request(encode_imm(msxu_pkg::OP_LUI, 5'd0, 5'd7, 16'h7000));
      push_request(encode_imm(msxu_pkg::OP_SW, 5'd7, 5'd1, 16'h3FFF));   // last scratch byte
      push_request(encode_imm(msxu_pkg::OP_SW, 5'd7, 5'd3, 16'h4000));   // just past scratch
      push_request(encode_imm(msxu_pkg::OP_SW, 5'd0, 5'd4, 16'hFFFF));   // top of space
      push_request(msxu_pkg::TLBWI_WORD);
      push_request(32'h0);
      push_request({msxu_pkg::OP_SPECIAL, 20'($urandom), msxu_pkg::FN_SYNC});
      push_request({msxu_pkg::OP_COP0, msxu_pkg::CP0_MF, 21'($urandom)});
      push_request({msxu_pkg::OP_COP0, msxu_pkg::CP0_MT, 21'($urandom)});
      push_request(encode_imm(msxu_pkg::OP_BNE, 5'd1, 5'd0, 16'hFFFF)); // taken, backward
      push_request(encode_imm(msxu_pkg::OP_BNE, 5'd3, 5'd1, 16'h0002)); // branch in slot
      push_request(encode_imm(msxu_pkg::OP_SPECIAL, 5'd7, 5'd0, {10'h0, msxu_pkg::FN_JR}));
      push_request(32'h0);
      push_request(encode_imm(msxu_pkg::OP_BNE, 5'd2, 5'd0, 16'h0010)); // not taken
      push_request(32'h0);
   endtask

   // One code that stops the unit, then a few requests it must ignore.
   task automatic queue_stop_tail();
      logic [31:0] word;
      logic [5:0]  op;
      logic [14:0] junk;
      case ($urandom_range(0, 3))
         0: begin
            op = 6'($urandom_range(0, 63));
            if (op == msxu_pkg::FN_JR || op == msxu_pkg::FN_SYNC)
               op = 6'h01;
            word = {msxu_pkg::OP_SPECIAL, 20'($urandom), op};
            if (word == 32'h0)
               word[0] = 1'b1;
         end
         1: begin
            junk = 15'($urandom);
            if (junk == 15'h0)
               junk = 15'h1;
            word = {msxu_pkg::OP_SPECIAL, pick_reg(), junk, msxu_pkg::FN_JR};
         end
         2: begin
            word = {msxu_pkg::OP_COP0, 5'($urandom_range(0, 31)), 21'($urandom)};
            if (word[25:21] == msxu_pkg::CP0_MF || word[25:21] == msxu_pkg::CP0_MT)
               word[25:21] = 5'd16;
            if (word == msxu_pkg::TLBWI_WORD)
               word[0] = 1'b1;
         end
         default: begin
            op = 6'($urandom_range(0, 63));
            case (op)
               msxu_pkg::OP_SPECIAL, msxu_pkg::OP_BNE, msxu_pkg::OP_ADDI,
               msxu_pkg::OP_ADDIU, msxu_pkg::OP_SLTI, msxu_pkg::OP_ORI,
               msxu_pkg::OP_LUI, msxu_pkg::OP_COP0, msxu_pkg::OP_SW: op = 6'h3F;
               default: ;
            endcase
            word = {op, 26'($urandom)};
         end
      endcase
      push_request(word);
      repeat (6) push_request(random_instruction());
   endtask

   // Hold until every queued request has retired and been checked.
   task automatic drain();
      while (retires_checked < requests_queued)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: offer queued words, predict each accepted request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      int i;
      if (reset) begin
         req_valid <= 1'b0;
         for (i = 0; i < 32; i++)
            arch_regs[i] = 32'h0;
         arch_pc      = msxu_pkg::BOOT_VECTOR;
         slot_pending = 1'b0;
         slot_target  = 32'h0;
         halted       = 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_retires.push_back(execute_instruction(req_instruction));
         // advance only when the slot is free; otherwise hold valid and payload
         if (!req_valid || req_ready) begin
            if (instr_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid       <= 1'b1;
               req_instruction <= instr_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: compare each retired request with the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      retire_info_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_retires.size() == 0) begin
               $display("%0t: response with no request pending, expected none, actual %h",
                        $time, rsp_fetch_address);
               mismatch_count++;
            end else begin
               want = predicted_retires.pop_front();
               check_field("status", {29'h0, want.status}, {29'h0, rsp_status});
               check_field("store_valid", {31'h0, want.store_valid},
                           {31'h0, rsp_store_valid});
               check_field("store_to_scratchpad", {31'h0, want.store_to_scratchpad},
                           {31'h0, rsp_store_to_scratchpad});
               check_field("store_address", want.store_address, rsp_store_address);
               check_field("store_data", want.store_data, rsp_store_data);
               check_field("fetch_address", want.fetch_address, rsp_fetch_address);
               retires_checked++;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, then four traffic phases; the unit is stopped only
   // at the very end since reset is applied once.
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // full rate on both sides
      queue_directed();
      queue_random_traffic(250);
      drain();

      // sparse sender
      sender_idle_pct    = 81;
      receiver_stall_pct = 0;
      queue_random_traffic(250);
      drain();

      // back-pressured receiver
      sender_idle_pct    = 0;
      receiver_stall_pct = 81;
      queue_random_traffic(250);
      drain();

      // both sides idling now and then
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      queue_random_traffic(250);
      queue_stop_tail();
      drain();

      // let any stray response show up
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[mips_subset_execute_unit_core] OK");
      else
         $display("[mips_subset_execute_unit_core] ERROR");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("[mips_subset_execute_unit_core] ERROR");
      $finish;
   end

endmodule

[mips_subset_execute_unit_core.f]
src/msxu_pkg.sv
src/msxu_regfile.sv
src/mips_subset_execute_unit_core.sv
tb/mips_subset_execute_unit_core_tb.sv
